/* hdl/tdsk_pkg.sv */
// ----------------------------------------------------------------------------
// tdsk_pkg
// Shared types and opcode constants of the table-driven seed/key core.
// ----------------------------------------------------------------------------
package tdsk_pkg;

  // Opcodes of one table triple.
  localparam logic [7:0] OPC_SWAP      = 8'h05;
  localparam logic [7:0] OPC_ADD_HL    = 8'h14;
  localparam logic [7:0] OPC_NOT_INC   = 8'h2A;
  localparam logic [7:0] OPC_AND_LH    = 8'h37;
  localparam logic [7:0] OPC_ROL       = 8'h4C;
  localparam logic [7:0] OPC_OR_LH     = 8'h52;
  localparam logic [7:0] OPC_ROR       = 8'h6b;
  localparam logic [7:0] OPC_ADD_LH    = 8'h75;
  localparam logic [7:0] OPC_SWAP_ADD  = 8'h7e;
  localparam logic [7:0] OPC_SUB_HL    = 8'h98;
  localparam logic [7:0] OPC_SUB_LH    = 8'hf8;

  // Protocol codes that select the second and third table.
  localparam logic [7:0] PROTO_SECOND  = 8'd2;
  localparam logic [7:0] PROTO_THIRD   = 8'd3;

  // Request operation codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // One opcode/operand triple as read from a table.
  typedef struct packed {
    logic [7:0] code;
    logic [7:0] hh;
    logic [7:0] ll;
  } triple_t;

endpackage

/* hdl/tdsk_ram.sv */
// ----------------------------------------------------------------------------
// tdsk_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tdsk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 9984,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/tdsk_alu.sv */
// ----------------------------------------------------------------------------
// tdsk_alu
// Shared step unit: applies one table triple to the running 16-bit value.
// ----------------------------------------------------------------------------
module tdsk_alu (
  input  logic [15:0]      value,
  input  tdsk_pkg::triple_t triple,
  output logic [15:0]      result
);
  import tdsk_pkg::*;

  logic [15:0] hl;
  logic [15:0] lh;
  logic [15:0] swapped;
  logic [31:0] rol_wide;
  logic [31:0] ror_wide;

  assign hl       = {triple.hh, triple.ll};
  assign lh       = {triple.ll, triple.hh};
  assign swapped  = {value[7:0], value[15:8]};
  // Rotates use the doubled word so that bits shifted out wrap round; an amount of zero passes the value.
  assign rol_wide = {value, value} << triple.hh[3:0];
  assign ror_wide = {value, value} >> triple.ll[3:0];

  always_comb begin
    unique case (triple.code)
      OPC_SWAP:     result = swapped;
      OPC_ADD_HL:   result = value + hl;
      OPC_NOT_INC:  result = ~value + {15'd0, (triple.hh < triple.ll)};
      OPC_AND_LH:   result = value & lh;
      OPC_ROL:      result = rol_wide[31:16];
      OPC_OR_LH:    result = value | lh;
      OPC_ROR:      result = ror_wide[15:0];
      OPC_ADD_LH:   result = value + lh;
      OPC_SWAP_ADD: result = swapped + ((triple.hh >= triple.ll) ? hl : lh);
      OPC_SUB_HL:   result = value - hl;
      OPC_SUB_LH:   result = value - lh;
      default:      result = value;
    endcase
  end

endmodule

/* hdl/table_driven_seed_key_core.sv */
// ----------------------------------------------------------------------------
// table_driven_seed_key_core
// Turns a 16-bit seed into a 16-bit key using opcode triples from loadable
// byte tables held in one block RAM.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------
//  input   | in        | in_valid / in_ready  | op, protocol, load_address,
//          |           |                      | load_byte, seed, algorithm
//  output  | out       | out_valid / out_ready| key
//
// A load request writes its byte in the cycle it is accepted and returns no
// result. A compute request with algorithm 0 goes straight to the finishing
// state. Any other compute request first reduces the algorithm number by
// subtracting NUM_ALGOS while it is not below it (never when NUM_ALGOS is
// 256), then sets up the table offset and runs STEPS steps; each step reads
// the three triple bytes through the single registered RAM read port one per
// cycle and then applies the triple. The block takes one request at a
// time; a finished key waits in the output register, and the next request is
// accepted meanwhile. Reset is synchronous and clears control state only; the
// table RAM is undefined until loaded.
// ----------------------------------------------------------------------------
module table_driven_seed_key_core #(
  parameter int NUM_TABLES   = 3,
  parameter int NUM_ALGOS    = 256,
  parameter int ENTRY_STRIDE = 13,
  parameter int STEPS        = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  protocol,
  input  logic [11:0] load_address,
  input  logic [7:0]  load_byte,
  input  logic [15:0] seed,
  input  logic [7:0]  algorithm,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] key
);
  import tdsk_pkg::*;

  localparam int TABLE_BYTES = NUM_ALGOS * ENTRY_STRIDE;
  localparam int STORE_BYTES = NUM_TABLES * TABLE_BYTES;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  // The table index can run past the end of the table by one program of 3 * STEPS bytes at most.
  localparam int IDX_W       = $clog2(TABLE_BYTES + 3 * STEPS + 1);
  localparam int STEP_W      = (STEPS > 1) ? $clog2(STEPS) : 1;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_SETUP  = 6'b000100,
    S_READ   = 6'b001000,
    S_APPLY  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t            state;
  logic [1:0]        tsel;       // selected table of the running compute
  logic [7:0]        algo;       // algorithm number, reduced in place
  logic [IDX_W-1:0]  idx;        // byte offset of the next read in the table
  logic [1:0]        byte_cnt;   // which byte of the triple is being fetched
  logic [STEP_W-1:0] step_cnt;
  logic              triple_ok;  // the current triple lies inside the table
  logic [7:0]        code_q;
  logic [7:0]        hh_q;
  logic [15:0]       value;

  logic              accept;
  logic [1:0]        tsel_in;
  logic              ram_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  triple_t           triple;
  logic [15:0]       alu_result;
  logic              out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Table selection: a protocol naming a table that is not built falls back
  // to the first table.
  always_comb begin
    priority if (protocol == PROTO_SECOND && NUM_TABLES > 1) begin
      tsel_in = 2'd1;
    end else if (protocol == PROTO_THIRD && NUM_TABLES > 2) begin
      tsel_in = 2'd2;
    end else begin
      tsel_in = 2'd0;
    end
  end

  // Loads outside the table are accepted but write nothing.
  assign ram_we  = accept && (op == OP_LOAD) && ({1'b0, load_address} < 13'(TABLE_BYTES));
  assign wr_addr = ADDR_W'(tsel_in * TABLE_BYTES) + ADDR_W'(load_address);
  assign rd_addr = ADDR_W'(tsel * TABLE_BYTES) + ADDR_W'(idx);

  tdsk_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (load_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The last byte of the triple is used straight from the RAM output.
  always_comb begin
    if (triple_ok) begin
      triple = '{code: code_q, hh: hh_q, ll: rd_data};
    end else begin
      triple = '0;
    end
  end

  tdsk_alu u_alu (
    .value  (value),
    .triple (triple),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      byte_cnt  <= 2'd0;
      step_cnt  <= '0;
      triple_ok <= 1'b0;
    end else begin
      // A finished key loads the output register whenever it is free; the
      // register empties when its key is taken and no new one arrives.
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && op == OP_COMPUTE) begin
            tsel <= tsel_in;
            algo <= algorithm;
            // Algorithm zero means the plain complement, decided before
            // any reduction of the algorithm number.
            if (algorithm == 8'd0) begin
              value <= ~seed;
              state <= S_FINISH;
            end else begin
              value <= seed;
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if ({1'b0, algo} >= 9'(NUM_ALGOS)) begin
            algo <= algo - 8'(NUM_ALGOS);
          end else begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          idx      <= IDX_W'(algo * ENTRY_STRIDE);
          byte_cnt <= 2'd0;
          step_cnt <= '0;
          state    <= S_READ;
        end
        S_READ: begin
          idx <= idx + IDX_W'(1);
          if (byte_cnt == 2'd0) begin
            triple_ok <= ((idx + IDX_W'(2)) < IDX_W'(TABLE_BYTES));
          end
          if (byte_cnt == 2'd1) begin
            code_q <= rd_data;
          end
          if (byte_cnt == 2'd2) begin
            hh_q     <= rd_data;
            byte_cnt <= 2'd0;
            state    <= S_APPLY;
          end else begin
            byte_cnt <= byte_cnt + 2'd1;
          end
        end
        S_APPLY: begin
          value <= alu_result;
          if (step_cnt == STEP_W'(STEPS - 1)) begin
            state <= S_FINISH;
          end else begin
            step_cnt <= step_cnt + STEP_W'(1);
            state    <= S_READ;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            key   <= value;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A key appears only from the finishing state.
  a_key_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("key shown without a finished compute");

  // The table is written only while no compute is running.
  a_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE))
    else $error("table write during a compute");

  // The byte counter stays within one triple.
  a_byte_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (byte_cnt != 2'd3))
    else $error("byte counter out of range");

  // A new key never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !out_ready) |=> (state == S_FINISH))
    else $error("finished compute left while output stalled");

endmodule

/* verif/seed_key_checker.sv */
// ----------------------------------------------------------------------------
// seed_key_checker
// Watches both channels of the seed/key core, keeps its own copy of the
// opcode tables, works out the key of every accepted compute request, and
// compares each key that leaves the core against the oldest one predicted.
// ----------------------------------------------------------------------------
module seed_key_checker #(
  parameter int NUM_TABLES   = 3,
  parameter int NUM_ALGOS    = 256,
  parameter int ENTRY_STRIDE = 13,
  parameter int STEPS        = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        op,
  input  logic [7:0]  protocol,
  input  logic [11:0] load_address,
  input  logic [7:0]  load_byte,
  input  logic [15:0] seed,
  input  logic [7:0]  algorithm,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] key,
  output int          fail_count,
  output int          keys_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tdsk_pkg::*;

  localparam int TABLE_BYTES = NUM_ALGOS * ENTRY_STRIDE;

  logic [7:0]  table_mem [NUM_TABLES * TABLE_BYTES];
  logic [15:0] expected_keys [$];
  logic [15:0] want;

  function automatic int table_of(logic [7:0] proto);
    int t;
    t = 0;
    if (proto == PROTO_SECOND) t = 1;
    else if (proto == PROTO_THIRD) t = 2;
    if (t >= NUM_TABLES) t = 0;
    return t;
  endfunction

  function automatic logic [15:0] apply_triple(logic [15:0] v, triple_t tr);
    logic [15:0] hl;
    logic [15:0] lh;
    logic [15:0] sw;
    logic [31:0] dbl;
    hl  = {tr.hh, tr.ll};
    lh  = {tr.ll, tr.hh};
    sw  = {v[7:0], v[15:8]};
    dbl = {v, v};
    case (tr.code)
      OPC_SWAP:     return sw;
      OPC_ADD_HL:   return v + hl;
      OPC_NOT_INC:  return ~v + ((tr.hh < tr.ll) ? 16'd1 : 16'd0);
      OPC_AND_LH:   return v & lh;
      OPC_ROL: begin
        dbl = dbl << tr.hh[3:0];
        return dbl[31:16];
      end
      OPC_OR_LH:    return v | lh;
      OPC_ROR: begin
        dbl = dbl >> tr.ll[3:0];
        return dbl[15:0];
      end
      OPC_ADD_LH:   return v + lh;
      OPC_SWAP_ADD: return sw + ((tr.hh >= tr.ll) ? hl : lh);
      OPC_SUB_HL:   return v - hl;
      OPC_SUB_LH:   return v - lh;
      default:      return v;
    endcase
  endfunction

  function automatic logic [15:0] predict_key(int tbl, logic [15:0] s, logic [7:0] alg);
    int          base;
    int          idx;
    int          k;
    triple_t     tr;
    logic [15:0] v;
    if (alg == 8'h00) return ~s;
    v    = s;
    base = tbl * TABLE_BYTES;
    idx  = (int'(alg) % NUM_ALGOS) * ENTRY_STRIDE;
    for (k = 0; k < STEPS; k++) begin
      if (idx + 2 < TABLE_BYTES)
        tr = {table_mem[base + idx], table_mem[base + idx + 1], table_mem[base + idx + 2]};
      else
        tr = '0;
      v = apply_triple(v, tr);
      idx += 3;
    end
    return v;
  endfunction

  // Keys leave before the same edge's request is taken in; a key can never
  // come back in the cycle its request was accepted.
  always @(posedge clk) begin
    if (rst) begin
      expected_keys.delete();
      fail_count   <= 0;
      keys_pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_keys.size() == 0) begin
          $error("key: no request outstanding, actual 0x%04h", key);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_keys.pop_front();
          if (key !== want) begin
            $error("key: expected 0x%04h, actual 0x%04h", want, key);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (op == OP_LOAD) begin
          if (load_address < TABLE_BYTES)
            table_mem[table_of(protocol) * TABLE_BYTES + load_address] = load_byte;
        end else begin
          expected_keys.push_back(predict_key(table_of(protocol), seed, algorithm));
        end
      end
      keys_pending <= expected_keys.size();
    end
  end

endmodule

/* verif/tb_table_driven_seed_key_core.sv */
// ----------------------------------------------------------------------------
// tb_table_driven_seed_key_core
// Drives load and compute requests into the seed/key core under changing
// idle patterns; the checker beside the core predicts and compares every key.
// ----------------------------------------------------------------------------
module tb_table_driven_seed_key_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tdsk_pkg::*;

  localparam int NUM_TABLES   = 3;
  localparam int NUM_ALGOS    = 256;
  localparam int ENTRY_STRIDE = 13;
  localparam int STEPS        = 4;
  localparam int TABLE_BYTES  = NUM_ALGOS * ENTRY_STRIDE;
  localparam int PROG_BYTES   = 3 * STEPS;

  // Counted requests in the random part, and where the idle pattern changes.
  localparam int RANDOM_REQS  = 1250;
  localparam int PHASE_TWO_AT = 420;
  localparam int PHASE_ONE_AT = 840;

  // Length of the one long output stall that backs the core up.
  localparam int HOLD_CYCLES  = 400;

  // Each key takes its time in the core, and with the slowest idle pattern
  // the sender and the receiver each add to it per request. This bound is
  // several times the slowest correct run.
  localparam int CYCLE_LIMIT  = 500_000;

  // Cycles to watch the output after the last key, well past the latency.
  localparam int DRAIN_CYCLES = 50;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        op           = OP_LOAD;
  logic [7:0]  protocol     = 8'h00;
  logic [11:0] load_address = 12'h000;
  logic [7:0]  load_byte    = 8'h00;
  logic [15:0] seed         = 16'h0000;
  logic [7:0]  algorithm    = 8'h00;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [15:0] key;

  int fail_count;
  int keys_pending;

  // Idle percentages of the two sides. The sender's is only read by the
  // stimulus process; the receiver's is handed over with a nonblocking write.
  int tx_idle_pct = 37;
  int rx_idle_pct = 70;

  // One long receiver stall is requested by the stimulus and then counted
  // down inside the receiver's own process.
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int cycle_count = 0;

  // Stimulus bookkeeping: which (table, algorithm) pairs have a complete
  // program and so may be computed.
  int ready_algos [$];
  int n_loads   = 0;
  int n_ignored = 0;
  int n_keys    = 0;

  always #5 clk = ~clk;

  table_driven_seed_key_core #(
    .NUM_TABLES  (NUM_TABLES),
    .NUM_ALGOS   (NUM_ALGOS),
    .ENTRY_STRIDE(ENTRY_STRIDE),
    .STEPS       (STEPS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .protocol    (protocol),
    .load_address(load_address),
    .load_byte   (load_byte),
    .seed        (seed),
    .algorithm   (algorithm),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key         (key)
  );

  seed_key_checker #(
    .NUM_TABLES  (NUM_TABLES),
    .NUM_ALGOS   (NUM_ALGOS),
    .ENTRY_STRIDE(ENTRY_STRIDE),
    .STEPS       (STEPS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .protocol    (protocol),
    .load_address(load_address),
    .load_byte   (load_byte),
    .seed        (seed),
    .algorithm   (algorithm),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key         (key),
    .fail_count  (fail_count),
    .keys_pending(keys_pending)
  );

  // The receiver. Outside the long stall it takes a key with the chance
  // set by rx_idle_pct.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: a lost key or a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it is accepted. Valid
  // is only lowered when a gap is taken, so a back-to-back request never
  // sees valid dropped and raised in the same time step.
  task automatic send_req(input logic op_v, input logic [7:0] proto_v,
                          input logic [11:0] addr_v, input logic [7:0] byte_v,
                          input logic [15:0] seed_v, input logic [7:0] alg_v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= op_v;
    protocol     <= proto_v;
    load_address <= addr_v;
    load_byte    <= byte_v;
    seed         <= seed_v;
    algorithm    <= alg_v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // A protocol value that selects table t. The first table answers to every
  // value other than the two special codes, so it gets a random one.
  function automatic logic [7:0] proto_for(int t);
    logic [7:0] p;
    if (t == 1) return PROTO_SECOND;
    if (t == 2) return PROTO_THIRD;
    do p = 8'($urandom); while (p == PROTO_SECOND || p == PROTO_THIRD);
    return p;
  endfunction

  // The fields that a request does not use still get random values, so
  // every input bit toggles.
  task automatic load_entry(input int t, input int addr, input logic [7:0] data);
    send_req(OP_LOAD, proto_for(t), 12'(addr), data, 16'($urandom), 8'($urandom));
    if (addr < TABLE_BYTES) begin
      n_loads++;
    end else begin
      n_ignored++;
    end
  endtask

  task automatic request_key(input int t, input logic [15:0] seed_v, input logic [7:0] alg_v);
    send_req(OP_COMPUTE, proto_for(t), 12'($urandom), 8'($urandom), seed_v, alg_v);
    n_keys++;
  endtask

  task automatic load_triple(input int t, input int a, input int step,
                             input logic [7:0] code, input logic [7:0] hh,
                             input logic [7:0] ll);
    load_entry(t, a * ENTRY_STRIDE + 3 * step,     code);
    load_entry(t, a * ENTRY_STRIDE + 3 * step + 1, hh);
    load_entry(t, a * ENTRY_STRIDE + 3 * step + 2, ll);
  endtask

  // Mostly known opcodes, with some random bytes so that unknown codes
  // (which pass the value through) turn up as well.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(99) >= 85) return 8'($urandom);
    case ($urandom_range(10))
      0:       return OPC_SWAP;
      1:       return OPC_ADD_HL;
      2:       return OPC_NOT_INC;
      3:       return OPC_AND_LH;
      4:       return OPC_ROL;
      5:       return OPC_OR_LH;
      6:       return OPC_ROR;
      7:       return OPC_ADD_LH;
      8:       return OPC_SWAP_ADD;
      9:       return OPC_SUB_HL;
      default: return OPC_SUB_LH;
    endcase
  endfunction

  // Writes the first nbytes of a random program for algorithm a. A short
  // write models a broken sequence; only a full one makes the pair usable.
  task automatic load_program(input int t, input int a, input int nbytes);
    logic [7:0] prog [PROG_BYTES];
    int         s;
    for (s = 0; s < STEPS; s++) begin
      prog[3 * s]     = pick_code();
      prog[3 * s + 1] = 8'($urandom);
      // Equal operands hit the boundary of the compare-driven opcodes.
      prog[3 * s + 2] = ($urandom_range(3) == 0) ? prog[3 * s + 1] : 8'($urandom);
    end
    for (s = 0; s < nbytes; s++) load_entry(t, a * ENTRY_STRIDE + s, prog[s]);
    if (nbytes == PROG_BYTES) ready_algos.push_back(t * NUM_ALGOS + a);
  endtask

  // The sender pauses here until every key asked for has come back. The
  // first edge lets the checker count the request just accepted.
  task automatic wait_drained();
    @(posedge clk);
    while (keys_pending != 0) @(posedge clk);
  endtask

  // Valid is dropped first so that the request just accepted is not
  // offered a second time while the sender waits.
  task automatic set_idling(input int tx_pct, input int rx_pct);
    in_valid <= 1'b0;
    wait_drained();
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  initial begin
    int pick;
    int t;
    int a;
    int entry;
    int phase;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Algorithm 0 is the plain complement whatever the
    // tables hold, so it is tried first at both seed extremes and both
    // protocol extremes.
    send_req(OP_COMPUTE, 8'h00, 12'hFFF, 8'hFF, 16'h0000, 8'h00);
    send_req(OP_COMPUTE, 8'hFF, 12'h000, 8'h00, 16'hFFFF, 8'h00);

    // Loads at the first address past a table and at the top of the
    // address range must be dropped without touching any table.
    load_entry(2, TABLE_BYTES, 8'hA5);
    load_entry(0, 4095, 8'h5A);

    // The last algorithm of the third table: a left rotate by 16 that
    // wraps to no rotate, a right rotate by 15, a complement with the
    // increment taken, and a swapped add with equal operands.
    load_triple(2, NUM_ALGOS - 1, 0, OPC_ROL,      8'd16, 8'h00);
    load_triple(2, NUM_ALGOS - 1, 1, OPC_ROR,      8'h00, 8'h0F);
    load_triple(2, NUM_ALGOS - 1, 2, OPC_NOT_INC,  8'h00, 8'hFF);
    load_triple(2, NUM_ALGOS - 1, 3, OPC_SWAP_ADD, 8'h80, 8'h80);
    ready_algos.push_back(2 * NUM_ALGOS + NUM_ALGOS - 1);
    request_key(2, 16'h0000, 8'(NUM_ALGOS - 1));
    request_key(2, 16'hFFFF, 8'(NUM_ALGOS - 1));

    // Random part. The long receiver stall starts right away, while the
    // sender keeps offering, so the core fills up and holds off its input.
    hold_go <= 1'b1;
    phase = 0;
    while (n_loads + n_keys < RANDOM_REQS + 16) begin
      if (phase == 0 && n_loads + n_keys >= PHASE_TWO_AT) begin
        set_idling(70, 37);
        phase = 1;
      end else if (phase == 1 && n_loads + n_keys >= PHASE_ONE_AT) begin
        set_idling(0, 0);
        phase = 2;
      end

      pick = $urandom_range(99);
      t    = $urandom_range(NUM_TABLES - 1);
      if (pick < 45) begin
        // Well-formed sequence: a full program, then a few keys from it.
        if ($urandom_range(9) == 0)
          a = ($urandom_range(1) == 0) ? 1 : NUM_ALGOS - 1;
        else
          a = $urandom_range(NUM_ALGOS - 1, 1);
        load_program(t, a, PROG_BYTES);
        repeat ($urandom_range(4, 1)) request_key(t, 16'($urandom), 8'(a));
      end else if (pick < 70 && ready_algos.size() > 0) begin
        entry = ready_algos[$urandom_range(ready_algos.size() - 1)];
        request_key(entry / NUM_ALGOS, 16'($urandom), 8'(entry % NUM_ALGOS));
      end else if (pick < 80) begin
        request_key(t, 16'($urandom), 8'h00);
      end else if (pick < 90) begin
        // Noise: a lone byte anywhere, in range or not.
        load_entry(t, $urandom_range(4095), 8'($urandom));
      end else begin
        load_program(t, $urandom_range(NUM_ALGOS - 1, 1), $urandom_range(PROG_BYTES - 1, 1));
      end
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d table loads, %0d dropped out-of-range loads and %0d key requests.",
             n_loads, n_ignored, n_keys);
    $display("Programs completed: %0d; idling 37/70, 70/37 and 0/0 with one %0d-cycle stall.",
             ready_algos.size(), HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* table_driven_seed_key_core.f */
hdl/tdsk_pkg.sv
hdl/tdsk_ram.sv
hdl/tdsk_alu.sv
hdl/table_driven_seed_key_core.sv
verif/seed_key_checker.sv
verif/tb_table_driven_seed_key_core.sv
